// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/gvs_pkg.sv
`default_nettype none
package gvs_pkg;

  localparam int ORBIT_COUNT = 73;
  localparam int COUNT_WIDTH = 24;
  localparam int ORBIT_W = 7;
  localparam int CNT_W = 24;
  localparam int X_W = CNT_W + 1;
  localparam int LN_W = 21;
  localparam int Q_W = 17;
  localparam int DIV_W = 48;
  localparam int DVS_W = 23;
  localparam int STEP_W = 6;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam int RATIO_STEPS = LN_W + 16;

  localparam logic [3:0] AFFECTED [73] = '{
    4'd1, 4'd2, 4'd2, 4'd2, 4'd3, 4'd4, 4'd3, 4'd3, 4'd4, 4'd3,
    4'd4, 4'd4, 4'd4, 4'd4, 4'd3, 4'd4, 4'd6, 4'd5, 4'd4, 4'd5,
    4'd6, 4'd6, 4'd4, 4'd4, 4'd4, 4'd5, 4'd7, 4'd4, 4'd6, 4'd6,
    4'd7, 4'd4, 4'd6, 4'd6, 4'd6, 4'd5, 4'd6, 4'd7, 4'd7, 4'd5,
    4'd7, 4'd6, 4'd7, 4'd6, 4'd5, 4'd5, 4'd6, 4'd8, 4'd7, 4'd6,
    4'd6, 4'd8, 4'd6, 4'd9, 4'd5, 4'd6, 4'd4, 4'd6, 4'd6, 4'd7,
    4'd8, 4'd6, 4'd6, 4'd8, 4'd7, 4'd6, 4'd7, 4'd7, 4'd8, 4'd5,
    4'd6, 4'd6, 4'd4
  };

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

  function automatic logic [63:0] ln_const(input logic [63:0] x);
    logic [63:0] xx;
    logic [63:0] m;
    logic [63:0] frac;
    logic [63:0] top;
    begin
      xx = (x == 64'd0) ? 64'd1 : x;
      top = 64'd0;
      for (int i = 1; i < 64; i++) begin
        if ((xx >> i) != 64'd0) top = 64'(i);
      end
      if (top <= 64'd30) m = xx << (64'd30 - top);
      else m = xx >> (top - 64'd30);
      frac = 64'd0;
      for (int i = 0; i < 16; i++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd1 << 31)) begin
          m = m >> 1;
          frac = frac | 64'd1;
        end
      end
      ln_const = (((top << 16) | frac) * {32'd0, LN2_Q32} + (64'd1 << 31)) >> 32;
    end
  endfunction

  localparam logic [63:0] LN_N = ln_const(64'(ORBIT_COUNT));

  function automatic logic [Q_W-1:0] weight_const(input int k);
    logic [63:0] r;
    begin
      if (LN_N == 64'd0) begin
        weight_const = Q_W'(65536);
      end else begin
        r = (ln_const(64'(AFFECTED[k])) << 16) / LN_N;
        weight_const = (r >= 64'd65536) ? '0 : Q_W'(64'd65536 - r);
      end
    end
  endfunction

  typedef logic [ORBIT_COUNT-1:0][Q_W-1:0] wtab_t;

  function automatic wtab_t build_wtab();
    wtab_t t;
    begin
      for (int k = 0; k < ORBIT_COUNT; k++) t[k] = weight_const(k);
      build_wtab = t;
    end
  endfunction

  function automatic logic [DVS_W-1:0] total_const();
    logic [63:0] s;
    begin
      s = 64'd0;
      for (int k = 0; k < ORBIT_COUNT; k++) s = s + 64'(weight_const(k));
      total_const = DVS_W'(s);
    end
  endfunction

  localparam wtab_t W_TAB = build_wtab();
  localparam logic [DVS_W-1:0] TOTAL_WEIGHT = total_const();
  // floor(2^39 / total weight): quotient estimate low by at most one for sums below total
  localparam logic [31:0] RECIP_TW = 32'((64'd1 << 39) / {41'd0, TOTAL_WEIGHT});

endpackage
`default_nettype wire

// File: hdl/gvs_mul.sv
`default_nettype none
module gvs_mul (
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] p
);
  assign p = {32'd0, a} * {32'd0, b};
endmodule
`default_nettype wire

// File: hdl/gvs_div.sv
`default_nettype none
module gvs_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire gvs_pkg::div_ctl_t             ctl,
  input  wire logic [gvs_pkg::DIV_W-1:0]     dividend,
  input  wire logic [gvs_pkg::DVS_W-1:0]     divisor,
  output logic                               busy,
  output logic      [gvs_pkg::DIV_W-1:0]     quotient
);
  logic                          busy_r;
  logic [gvs_pkg::STEP_W-1:0]    cnt_r;
  logic [gvs_pkg::DVS_W-1:0]     rem_r;
  logic [gvs_pkg::DVS_W-1:0]     dvs_r;
  logic [gvs_pkg::DIV_W-1:0]     q_r;
  logic [gvs_pkg::DVS_W:0]       trial;
  logic                          bit_q;
  logic [gvs_pkg::DVS_W:0]       diff;

  always_comb begin
    trial = {rem_r, q_r[gvs_pkg::DIV_W-1]};
    bit_q = trial >= {1'b0, dvs_r};
    diff  = trial - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      cnt_r  <= ctl.steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - gvs_pkg::STEP_W'(1);
      if (cnt_r == gvs_pkg::STEP_W'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      q_r   <= dividend;
    end else if (busy_r) begin
      rem_r <= bit_q ? diff[gvs_pkg::DVS_W-1:0] : trial[gvs_pkg::DVS_W-1:0];
      q_r   <= {q_r[gvs_pkg::DIV_W-2:0], bit_q};
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;
endmodule
`default_nettype wire

// File: hdl/graphlet_vector_similarity_top.sv
// Sequence: an accepted in-range request runs three logarithms on the shared 32x32 multiplier,
// then the bit-serial ratio divide, then the term that is added to the sum. A last request
// adds reciprocal multiply, correction and output load before out_valid.
// Flow: one request at a time, taken only while idle. A stalled result holds the block.
// An out-of-range request adds no term; when last it goes on to the reciprocal multiply.
// Reset: synchronous active-low rst_n clears the sequencer, the sum and the output valid.
`default_nettype none
`include "assert_macros.svh"
module graphlet_vector_similarity_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [gvs_pkg::ORBIT_W-1:0]       in_orbit,
  input  wire logic [gvs_pkg::CNT_W-1:0]         in_count_a,
  input  wire logic [gvs_pkg::CNT_W-1:0]         in_count_b,
  input  wire logic                              in_last_orbit,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [gvs_pkg::Q_W-1:0]           out_similarity
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NORM  = 4'd1;
  localparam logic [3:0] S_SQ    = 4'd2;
  localparam logic [3:0] S_CONV  = 4'd3;
  localparam logic [3:0] S_RDIV  = 4'd4;
  localparam logic [3:0] S_RWAIT = 4'd5;
  localparam logic [3:0] S_TERM  = 4'd6;
  localparam logic [3:0] S_FMUL  = 4'd7;
  localparam logic [3:0] S_FFIX  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  localparam logic [1:0] PH_A   = 2'd0;
  localparam logic [1:0] PH_B   = 2'd1;
  localparam logic [1:0] PH_DEN = 2'd2;

  logic [3:0]                    state_r, state_nxt;
  logic [1:0]                    phase_r;
  logic [3:0]                    sq_cnt_r;
  logic [gvs_pkg::ORBIT_W-1:0]   orbit_r;
  logic [gvs_pkg::CNT_W-1:0]     a_r, b_r;
  logic                          last_r;
  logic [30:0]                   m_r;
  logic [4:0]                    top_r;
  logic [15:0]                   frac_r;
  logic [gvs_pkg::LN_W-1:0]      la_r, lb_r, den_r;
  logic [gvs_pkg::Q_W-1:0]       ratio_r;
  logic [31:0]                   sum_r;
  logic [15:0]                   q0_r;
  logic [gvs_pkg::Q_W-1:0]       sim_r;
  logic                          out_valid_r;
  logic [gvs_pkg::Q_W-1:0]       out_sim_r;

  logic                          accept;
  logic                          in_range;
  logic [gvs_pkg::CNT_W-1:0]     cmax;
  logic [gvs_pkg::X_W-1:0]       x;
  logic [4:0]                    top;
  logic [30:0]                   m_norm;
  logic [31:0]                   mul_a, mul_b;
  logic [63:0]                   mul_p;
  logic [31:0]                   sq_t;
  logic [63:0]                   ln_full;
  logic [gvs_pkg::LN_W-1:0]      num;
  logic [17:0]                   term;
  logic [32:0]                   sum_add;
  logic                          fin_sat;
  logic [38:0]                   fin_rem;
  logic [gvs_pkg::Q_W-1:0]       weight;
  gvs_pkg::div_ctl_t             div_ctl;
  logic [gvs_pkg::DIV_W-1:0]     div_dividend;
  logic [gvs_pkg::DVS_W-1:0]     div_divisor;
  logic                          div_busy;
  logic [gvs_pkg::DIV_W-1:0]     div_q;
  logic                          out_load;

  assign in_stall = state_r != S_IDLE;
  assign accept   = in_valid && !in_stall;
  assign in_range = orbit_r < gvs_pkg::ORBIT_W'(gvs_pkg::ORBIT_COUNT);
  assign out_load = state_r == S_OUT && (!out_valid_r || !out_stall);

  always_comb begin
    cmax = (a_r > b_r) ? a_r : b_r;
    case (phase_r)
      PH_A:    x = {1'b0, a_r} + gvs_pkg::X_W'(1);
      PH_B:    x = {1'b0, b_r} + gvs_pkg::X_W'(1);
      default: x = {1'b0, cmax} + gvs_pkg::X_W'(2);
    endcase
    top = '0;
    for (int i = 0; i < gvs_pkg::X_W; i++) begin
      if (x[i]) top = 5'(i);
    end
    m_norm = {6'd0, x} << (5'd30 - top);
  end

  assign weight = gvs_pkg::W_TAB[orbit_r];

  always_comb begin
    case (state_r)
      S_SQ:    begin mul_a = {1'b0, m_r}; mul_b = {1'b0, m_r}; end
      S_CONV:  begin mul_a = {11'd0, top_r, frac_r}; mul_b = gvs_pkg::LN2_Q32; end
      S_TERM:  begin mul_a = {15'd0, weight}; mul_b = {15'd0, ratio_r}; end
      S_FMUL:  begin mul_a = {9'd0, sum_r[22:0]}; mul_b = gvs_pkg::RECIP_TW; end
      S_FFIX:  begin mul_a = {16'd0, q0_r}; mul_b = {9'd0, gvs_pkg::TOTAL_WEIGHT}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  gvs_mul u_mul (.a(mul_a), .b(mul_b), .p(mul_p));

  always_comb begin
    sq_t    = mul_p[61:30];
    ln_full = mul_p + 64'h0000_0000_8000_0000;
    num     = (la_r > lb_r) ? la_r - lb_r : lb_r - la_r;
    term    = mul_p[33:16];
    sum_add = {1'b0, sum_r} + {15'd0, term};
    fin_sat = sum_r >= {9'd0, gvs_pkg::TOTAL_WEIGHT};
    fin_rem = {sum_r[22:0], 16'd0} - mul_p[38:0];
  end

  always_comb begin
    div_ctl      = '0;
    div_dividend = '0;
    div_divisor  = '0;
    if (state_r == S_RDIV) begin
      div_ctl.start = 1'b1;
      div_ctl.steps = gvs_pkg::STEP_W'(gvs_pkg::RATIO_STEPS);
      div_dividend  = {num, 27'd0};
      div_divisor   = {2'd0, den_r};
    end
  end

  gvs_div u_div (
    .clk(clk), .rst_n(rst_n), .ctl(div_ctl), .dividend(div_dividend),
    .divisor(div_divisor), .busy(div_busy), .quotient(div_q)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_orbit < gvs_pkg::ORBIT_W'(gvs_pkg::ORBIT_COUNT)) state_nxt = S_NORM;
          else if (in_last_orbit) state_nxt = S_FMUL;
        end
      end
      S_NORM:  state_nxt = S_SQ;
      S_SQ:    if (sq_cnt_r == 4'd15) state_nxt = S_CONV;
      S_CONV:  state_nxt = (phase_r == PH_DEN) ? S_RDIV : S_NORM;
      S_RDIV:  state_nxt = S_RWAIT;
      S_RWAIT: if (!div_busy) state_nxt = S_TERM;
      S_TERM:  state_nxt = last_r ? S_FMUL : S_IDLE;
      S_FMUL:  state_nxt = S_FFIX;
      S_FFIX:  state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_A;
      sq_cnt_r    <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) phase_r <= PH_A;
      else if (state_r == S_CONV) phase_r <= phase_r + 2'd1;
      if (state_r == S_NORM) sq_cnt_r <= '0;
      else if (state_r == S_SQ) sq_cnt_r <= sq_cnt_r + 4'd1;
      if (state_r == S_TERM) sum_r <= sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
      else if (out_load) sum_r <= '0;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      orbit_r <= in_orbit;
      a_r     <= in_count_a;
      b_r     <= in_count_b;
      last_r  <= in_last_orbit;
    end
    if (state_r == S_NORM) begin
      m_r    <= m_norm;
      top_r  <= top;
      frac_r <= '0;
    end else if (state_r == S_SQ) begin
      m_r    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
      frac_r <= {frac_r[14:0], sq_t[31]};
    end
    if (state_r == S_CONV) begin
      case (phase_r)
        PH_A:    la_r  <= ln_full[52:32];
        PH_B:    lb_r  <= ln_full[52:32];
        default: den_r <= ln_full[52:32];
      endcase
    end
    if (state_r == S_RWAIT && !div_busy) ratio_r <= div_q[gvs_pkg::Q_W-1:0];
    if (state_r == S_FMUL) q0_r <= mul_p[38:23];
    if (state_r == S_FFIX) begin
      if (fin_sat) begin
        sim_r <= '0;
      end else if (fin_rem >= {16'd0, gvs_pkg::TOTAL_WEIGHT}) begin
        sim_r <= gvs_pkg::Q_W'(65536) - {1'b0, q0_r} - gvs_pkg::Q_W'(1);
      end else begin
        sim_r <= gvs_pkg::Q_W'(65536) - {1'b0, q0_r};
      end
    end
    if (out_load) out_sim_r <= sim_r;
  end

  assign out_valid      = out_valid_r;
  assign out_similarity = out_sim_r;

  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept && in_orbit < 7'd73, in_stall)
  `ASSERT_IMPL(a_out_from_busy, clk, rst_n, $rose(out_valid), $past(in_stall))
  `ASSERT_IMPL(a_no_range_skip, clk, rst_n, state_r == S_TERM, in_range)
endmodule
`default_nettype wire
